FILE: rtl/mfe_pkg.sv
// ----------------------------------------------------------------------------
// Modbus ASCII frame encoder package
// Character codes, function codes, the per-byte work descriptor shared by the
// front end, queue and character stage, and the hex digit encoder of the latter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfe_pkg;

  // ASCII characters of the frame
  localparam logic [6:0] CH_COLON       = 7'h3A;
  localparam logic [6:0] CH_CR          = 7'h0D;
  localparam logic [6:0] CH_LF          = 7'h0A;
  localparam logic [6:0] CH_ZERO        = 7'h30;
  localparam logic [6:0] CH_LETTER_BASE = 7'h37;  // 'A' - 10

  // Supported Modbus function codes
  localparam logic [7:0] FC_READ_COILS      = 8'd1;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FC_WRITE_REG       = 8'd6;
  localparam logic [7:0] FC_MULTI_COILS     = 8'd15;
  localparam logic [7:0] FC_MULTI_REGS      = 8'd16;

  // Default depth of the queue between front end and character stage
  localparam int QUEUE_DEPTH = 2;

  // One queued binary byte and what must be sent around it
  typedef struct packed {
    logic [7:0] data;   // binary byte to send as two hex digits
    logic [7:0] lrc;    // LRC to send after the byte when tail is set
    logic       lead;   // ':' goes in front (first byte of a frame)
    logic       tail;   // final byte: LRC, CR and LF follow
    logic       err;    // unsupported function: frame ends on this byte
  } desc_t;

  // Upper-case hex digit for one nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    return (nib >= 4'd10) ? (wide + CH_LETTER_BASE) : (wide + CH_ZERO);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mfe_fifo.sv
// ----------------------------------------------------------------------------
// Descriptor queue
// Short register queue between the front end and the character stage so
// that either side can stall without holding the other.
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_fifo #(
  parameter int DEPTH = mfe_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mfe_pkg::desc_t wdata,
  output logic               wready,
  input  wire logic          pop,
  output mfe_pkg::desc_t     rdata,
  output logic               rvalid
);
  import mfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           do_push;
  logic           do_pop;

  assign wready  = (count_r != CW'(DEPTH));
  assign rvalid  = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && wready;
  assign do_pop  = pop && rvalid;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a write");

  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count lost a read");
`endif

endmodule

`default_nettype wire

FILE: rtl/mfe_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts binary request bytes, tracks the position within the frame, the
// function code, the frame length and the running byte sum, and turns each
// byte into one descriptor for the character stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  output logic                push,
  output mfe_pkg::desc_t      desc,
  input  wire logic           q_ready
);
  import mfe_pkg::*;

  localparam logic [8:0] POS_FUNC       = 9'd1;
  localparam logic [8:0] POS_HDR_LAST   = 9'd3;
  localparam logic [8:0] POS_FIRST_DATA = 9'd4;
  localparam logic [8:0] POS_COUNT      = 9'd6;
  localparam logic [8:0] TOTAL_SINGLE   = 9'd6;
  localparam logic [8:0] TOTAL_MULTI    = 9'd7;

  logic [8:0] pos_r,   pos_nxt;
  logic [7:0] fc_r,    fc_nxt;
  logic [8:0] total_r, total_nxt;
  logic [7:0] sum_r,   sum_nxt;

  logic       first;
  logic       single;
  logic       multi;
  logic       err;
  logic       final_byte;
  logic [8:0] total_base;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // classify the byte
  always_comb begin
    first      = (pos_r == '0);
    sum_nxt    = (first ? 8'd0 : sum_r) + in_byte;
    fc_nxt     = (pos_r == POS_FUNC) ? in_byte : fc_r;
    total_base = first ? 9'd0 : total_r;
    single     = fc_nxt inside {FC_READ_COILS, FC_READ_INPUT_REGS,
                                FC_WRITE_COIL, FC_WRITE_REG};
    multi      = (fc_nxt == FC_MULTI_COILS) || (fc_nxt == FC_MULTI_REGS);
    err        = (pos_r == POS_HDR_LAST) && !single && !multi;

    total_nxt = total_base;
    if (pos_r == POS_HDR_LAST) begin
      if (single) begin
        total_nxt = TOTAL_SINGLE;
      end else if (multi) begin
        total_nxt = TOTAL_MULTI;
      end
    end else if ((pos_r == POS_COUNT) && multi) begin
      total_nxt = TOTAL_MULTI + {1'b0, in_byte};
    end

    final_byte = !err && (pos_r >= POS_FIRST_DATA) &&
                 (({1'b0, pos_r} + 10'd1) >= {1'b0, total_nxt});
    pos_nxt    = (err || final_byte) ? 9'd0 : pos_r + 9'd1;

    desc.data = in_byte;
    desc.lrc  = 8'd0 - sum_nxt;
    desc.lead = first;
    desc.tail = final_byte;
    desc.err  = err;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fc_r    <= '0;
      total_r <= '0;
      sum_r   <= '0;
    end else if (push) begin
      pos_r   <= pos_nxt;
      fc_r    <= fc_nxt;
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_no_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (push && desc.err) |-> (!desc.tail && !desc.lead))
    else $error("cut-short frame also marked final");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (desc.err || desc.tail)) |=> (pos_r == '0))
    else $error("frame did not restart after its last byte");

  a_lead_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (push && desc.lead) |=> (pos_r == POS_FUNC))
    else $error("position did not advance past the address");
`endif

endmodule

`default_nettype wire

FILE: rtl/mfe_back.sv
// ----------------------------------------------------------------------------
// Character stage
// Expands each queued descriptor into its ASCII characters, one a cycle
// unless the queue is empty or out_ready holds, into a registered output:
// optional ':', two hex digits, then LRC, CR, LF on a frame's final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mfe_pkg::desc_t head,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [6:0]          out_char,
  output logic                out_last,
  output logic                out_status
);
  import mfe_pkg::*;

  typedef enum logic [2:0] {
    ST_COLON,
    ST_HI,
    ST_LO,
    ST_LRC_HI,
    ST_LRC_LO,
    ST_CR,
    ST_LF
  } step_t;

  step_t      step_r;
  logic       started_r;
  logic       valid_r;
  logic [6:0] char_r;
  logic       last_r;
  logic       status_r;

  step_t      cur_step;
  step_t      step_nxt;
  logic       load;
  logic       desc_done;
  logic [6:0] char_nxt;
  logic       last_nxt;
  logic       status_nxt;

  assign out_valid  = valid_r;
  assign out_char   = char_r;
  assign out_last   = last_r;
  assign out_status = status_r;

  // pick the character for the current step
  always_comb begin
    if (started_r) begin
      cur_step = step_r;
    end else begin
      cur_step = head.lead ? ST_COLON : ST_HI;
    end
    load      = head_valid && (!valid_r || out_ready);
    desc_done = (cur_step == ST_LF) || ((cur_step == ST_LO) && !head.tail);
    pop       = load && desc_done;
    step_nxt  = step_t'(cur_step + 3'd1);

    case (cur_step)
      ST_COLON:  char_nxt = CH_COLON;
      ST_HI:     char_nxt = hex_char(head.data[7:4]);
      ST_LO:     char_nxt = hex_char(head.data[3:0]);
      ST_LRC_HI: char_nxt = hex_char(head.lrc[7:4]);
      ST_LRC_LO: char_nxt = hex_char(head.lrc[3:0]);
      ST_CR:     char_nxt = CH_CR;
      ST_LF:     char_nxt = CH_LF;
      default:   char_nxt = CH_LF;
    endcase

    status_nxt = head.err && ((cur_step == ST_HI) || (cur_step == ST_LO));
    last_nxt   = (cur_step == ST_LF) || (head.err && (cur_step == ST_LO));
  end

  // step sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_COLON;
      started_r <= 1'b0;
      valid_r   <= 1'b0;
      char_r    <= '0;
      last_r    <= 1'b0;
      status_r  <= 1'b0;
    end else if (load) begin
      valid_r   <= 1'b1;
      char_r    <= char_nxt;
      last_r    <= last_nxt;
      status_r  <= status_nxt;
      started_r <= !desc_done;
      step_r    <= step_nxt;
    end else if (out_ready) begin
      valid_r   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_status_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r) |->
      ((char_r >= CH_ZERO && char_r <= 7'h39) || (char_r >= 7'h41 && char_r <= 7'h46)))
    else $error("error status on a non-hex character");

  a_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r && !status_r) |-> (char_r == CH_LF))
    else $error("normal frame ended on something other than LF");

  a_started_head: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> head_valid)
    else $error("descriptor left the queue before all its characters");
`endif

endmodule

`default_nettype wire

FILE: rtl/modbus_ascii_frame_encoder.sv
// ----------------------------------------------------------------------------
// Modbus ASCII frame encoder
// Turns the binary bytes of a Modbus request into its ASCII frame with LRC.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : stream of binary request bytes (address, function, start address,
//           then the function's data bytes), one byte per transfer.
//   out_* : one ASCII character per transfer: ':' before the address, two
//           upper-case hex digits per byte, then LRC (two digits), CR, LF.
//           out_tlast marks the last character of a frame; out_tuser is set
//           on both digits of byte 3 when the function code is unsupported,
//           which ends the frame there with no LRC, CR or LF.
//   Each byte's descriptor is written into the queue, and each of its
//   characters is then registered in the output register. Characters
//   leave one per cycle while a descriptor waits and out_tready is high:
//   two digits per middle byte, ':' and two digits for the address byte,
//   and two digits, LRC, CR and LF for the final byte of a frame. A small
//   descriptor queue sits between the byte classifier and the character
//   stage, so new bytes are taken while earlier characters still wait.
//   Reset clears the frame position, sum and queue; the next byte is taken
//   as an address. When out_tready is low the current character holds and
//   input transfers stop once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_ascii_frame_encoder #(
  parameter int FIFO_DEPTH = mfe_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] data_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [6:0] ascii_char, [7] zero
  output logic            out_tlast,   // frame_end
  output logic            out_tuser    // [0] frame_status
);
  import mfe_pkg::*;

  desc_t      front_desc;
  desc_t      head_desc;
  logic       front_push;
  logic       q_ready;
  logic       head_valid;
  logic       back_pop;
  logic [6:0] out_char;

  // byte classifier
  mfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .push     (front_push),
    .desc     (front_desc),
    .q_ready  (q_ready)
  );

  // descriptor queue
  mfe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (front_push),
    .wdata  (front_desc),
    .wready (q_ready),
    .pop    (back_pop),
    .rdata  (head_desc),
    .rvalid (head_valid)
  );

  // character stage
  mfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_desc),
    .head_valid (head_valid),
    .pop        (back_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire
